/* sv/prsn_pkg.sv */
package prsn_pkg;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic CFG_TRIGGER_PORT  = 1'b0;
  localparam logic CFG_REDIRECT_ADDR = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_PASS,
    VERDICT_FWD,
    VERDICT_REPLY
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_OUT
  } state_t;

  // Lookup request that walks the session cells, one cell per cycle.
  typedef struct packed {
    logic        valid;
    logic        fwd;
    logic        hit;
    logic        stored;
    logic [47:0] key;
    logic [31:0] new_server;
    logic [31:0] server;
  } probe_t;

  // Incremental ones' complement update for a 32-bit field (RFC 1624, eqn. 3).
  function automatic logic [15:0] csum_adjust32(input logic [15:0] hc,
                                                input logic [31:0] old_v,
                                                input logic [31:0] new_v);
    logic [15:0] n_hc;
    logic [15:0] n_hi;
    logic [15:0] n_lo;
    logic [18:0] s;
    logic [16:0] f1;
    logic [16:0] f2;
    n_hc = ~hc;
    n_hi = ~old_v[31:16];
    n_lo = ~old_v[15:0];
    s  = 19'(n_hc) + 19'(n_hi) + 19'(n_lo) + 19'(new_v[31:16]) + 19'(new_v[15:0]);
    f1 = 17'(s[15:0]) + 17'(s[18:16]);
    f2 = 17'(f1[15:0]) + 17'(f1[16]);
    return ~f2[15:0];
  endfunction

  // A UDP checksum of zero means "none" and stays zero; a computed zero goes out as all ones.
  function automatic logic [15:0] l4_adjust(input logic [7:0] proto,
                                            input logic [15:0] hc,
                                            input logic [31:0] old_v,
                                            input logic [31:0] new_v);
    logic        udp;
    logic [15:0] r;
    udp = (proto == PROTO_UDP);
    r = csum_adjust32(hc, old_v, new_v);
    if (udp && hc == 16'h0000) begin
      r = 16'h0000;
    end else if (udp && r == 16'h0000) begin
      r = 16'hFFFF;
    end
    return r;
  endfunction

endpackage

/* sv/port_redirect_session_nat_top.sv */
// Destination NAT port redirect with a session table of SESSION_SLOTS entries,
// held in a row of cells. Each header request walks the whole row, one cell per
// cycle, and its result is registered when it leaves the last cell. The next
// request is taken in the cycle after the result has been delivered, so the
// block holds one request at a time. A forward request records its client in the
// first free cell during the same walk; the checksums are updated incrementally
// at the row's end. Configuration writes are always accepted and must only be
// issued while the block is idle.
module port_redirect_session_nat_top
  import prsn_pkg::*;
#(
  parameter int SESSION_SLOTS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // protocol, source address, destination address, source port, destination port,
  // IP checksum, L4 checksum
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new source address, new destination address, IP checksum, L4 checksum
  output logic [95:0]  m_tdata,
  // verdict, table_full
  output logic [2:0]   m_tuser
);

  logic [15:0] trigger_port;
  logic [31:0] redirect_addr;

  state_t state;
  state_t state_next;

  logic [7:0]  protocol;
  logic [31:0] pkt_saddr;
  logic [31:0] pkt_daddr;
  logic [15:0] ip_checksum;
  logic [15:0] l4_checksum;
  logic        is_fwd;
  logic        is_reply;

  probe_t chain [SESSION_SLOTS+1];

  logic        in_take;
  logic        search_done;
  logic        in_l4;
  logic        in_fwd;
  logic        in_reply;
  logic [7:0]  in_protocol;
  logic [31:0] in_saddr;
  logic [31:0] in_daddr;
  logic [15:0] in_sport;
  logic [15:0] in_dport;

  logic [31:0] old_addr;
  logic [31:0] new_addr;
  logic [15:0] adj_ip;
  logic [15:0] adj_l4;
  verdict_t    verdict;
  logic [31:0] res_src;
  logic [31:0] res_dst;
  logic [15:0] res_ip;
  logic [15:0] res_l4;
  logic        res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_port  <= '0;
      redirect_addr <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TRIGGER_PORT:  trigger_port  <= cfg_data[15:0];
        CFG_REDIRECT_ADDR: redirect_addr <= cfg_data;
        default:           trigger_port  <= trigger_port;
      endcase
    end
  end

  assign in_protocol = s_tdata[7:0];
  assign in_saddr    = s_tdata[39:8];
  assign in_daddr    = s_tdata[71:40];
  assign in_sport    = s_tdata[87:72];
  assign in_dport    = s_tdata[103:88];

  assign in_l4    = (in_protocol == PROTO_TCP) || (in_protocol == PROTO_UDP);
  assign in_fwd   = in_l4 && (in_dport == trigger_port) && (in_saddr != redirect_addr);
  assign in_reply = in_l4 && !in_fwd && (in_saddr == redirect_addr) &&
                    (in_sport == trigger_port);

  assign search_done = chain[SESSION_SLOTS].valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (search_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_take = s_tvalid && s_tready;

  // Head of the cell row: a one-cycle request launched at acceptance.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid      <= in_take;
      chain[0].fwd        <= in_fwd;
      chain[0].hit        <= 1'b0;
      chain[0].stored     <= 1'b0;
      chain[0].key        <= in_fwd ? {in_saddr, in_sport} : {in_daddr, in_dport};
      chain[0].new_server <= in_daddr;
      chain[0].server     <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      protocol    <= in_protocol;
      pkt_saddr   <= in_saddr;
      pkt_daddr   <= in_daddr;
      ip_checksum <= s_tdata[119:104];
      l4_checksum <= s_tdata[135:120];
      is_fwd      <= in_fwd;
      is_reply    <= in_reply;
    end
  end

  for (genvar i = 0; i < SESSION_SLOTS; i++) begin : g_cell
    prsn_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_in  (chain[i]),
      .probe_out (chain[i+1])
    );
  end

  // One pair of checksum adjusters, IP and L4, serves both directions.
  assign old_addr = is_fwd ? pkt_daddr : pkt_saddr;
  assign new_addr = is_fwd ? redirect_addr : chain[SESSION_SLOTS].server;
  assign adj_ip   = csum_adjust32(ip_checksum, old_addr, new_addr);
  assign adj_l4   = l4_adjust(protocol, l4_checksum, old_addr, new_addr);

  always_comb begin
    verdict  = VERDICT_PASS;
    res_src  = pkt_saddr;
    res_dst  = pkt_daddr;
    res_ip   = ip_checksum;
    res_l4   = l4_checksum;
    res_full = 1'b0;
    if (is_fwd) begin
      verdict  = VERDICT_FWD;
      res_dst  = redirect_addr;
      res_ip   = adj_ip;
      res_l4   = adj_l4;
      res_full = !chain[SESSION_SLOTS].hit && !chain[SESSION_SLOTS].stored;
    end else if (is_reply && chain[SESSION_SLOTS].hit) begin
      verdict = VERDICT_REPLY;
      res_src = chain[SESSION_SLOTS].server;
      res_ip  = adj_ip;
      res_l4  = adj_l4;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEARCH && search_done) begin
      m_tdata <= {res_l4, res_ip, res_dst, res_src};
      m_tuser <= {res_full, verdict};
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output sides open at the same time");

  a_done_in_search: assert property (@(posedge clk) disable iff (rst)
    search_done |-> (state == ST_SEARCH))
    else $error("lookup finished outside of a search");

  a_full_fwd: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == VERDICT_FWD))
    else $error("table full flagged on a request that is not forwarded");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result dropped before it was taken");

endmodule

/* sv/prsn_cell.sv */
module prsn_cell
  import prsn_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  probe_t probe_in,
  output probe_t probe_out
);

  logic        entry_valid;
  logic [47:0] client_key;
  logic [31:0] server_addr;

  logic   match;
  logic   claim;
  probe_t probe_next;

  // Sessions are never removed, so valid cells form a prefix of the row. A new
  // key reaches the first empty cell only after every valid cell was checked.
  assign match = entry_valid && (client_key == probe_in.key);
  assign claim = probe_in.valid && !entry_valid && probe_in.fwd &&
                 !probe_in.hit && !probe_in.stored;

  always_comb begin
    probe_next        = probe_in;
    probe_next.hit    = probe_in.hit | match;
    probe_next.stored = probe_in.stored | claim;
    if (match && !probe_in.hit) begin
      probe_next.server = server_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid     <= 1'b0;
      probe_out.valid <= 1'b0;
    end else begin
      probe_out <= probe_next;
      if (claim) begin
        entry_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      client_key  <= probe_in.key;
      server_addr <= probe_in.new_server;
    end
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top
  import prsn_pkg::*;
();

  localparam int SLOTS = 64;
  localparam int IDLE_PCT = 26;
  localparam int RANDOM_PER_PHASE = 110;

  // Packed so that the first header field sits in the lowest bits of s_tdata.
  typedef struct packed {
    logic [15:0] l4c;
    logic [15:0] ipc;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [31:0] dst;
    logic [31:0] src;
    logic [7:0]  proto;
  } hdr_t;

  typedef struct {
    verdict_t    verdict;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] ipc;
    logic [15:0] l4c;
    logic        full;
  } rewrite_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = CFG_TRIGGER_PORT;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // protocol, source address, destination address, source port, destination port,
  // IP checksum, L4 checksum
  logic [135:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // new source address, new destination address, IP checksum, L4 checksum
  logic [95:0]  m_tdata;
  // verdict, table_full
  logic [2:0]   m_tuser;

  port_redirect_session_nat_top #(.SESSION_SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Session table and registers as the block should hold them.
  logic        sess_valid [SLOTS];
  logic [47:0] sess_client [SLOTS];
  logic [31:0] sess_server [SLOTS];
  int          sess_used = 0;
  logic [15:0] cur_trigger = '0;
  logic [31:0] cur_redirect = '0;

  hdr_t        header_q [$];
  rewrite_t    rewrite_q [$];
  logic [47:0] client_pool [$];
  rewrite_t    pred_r;
  rewrite_t    want_r;
  logic        quiet = 1'b0;
  int          fail_count = 0;
  int          n_requests = 0;
  int          n_fwd = 0;
  int          n_reply = 0;
  int          n_pass = 0;
  int          n_recorded = 0;
  int          n_refused = 0;
  int          n_settings = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) sess_valid[i] = 1'b0;
  end

  // Ones' complement incremental update of a checksum over a changed 32-bit word.
  function automatic logic [15:0] csum_swap(input logic [15:0] hc, input logic [31:0] from,
                                            input logic [31:0] to);
    logic [15:0] inv_hc;
    logic [15:0] inv_hi;
    logic [15:0] inv_lo;
    int unsigned acc;
    inv_hc = ~hc;
    inv_hi = ~from[31:16];
    inv_lo = ~from[15:0];
    acc = 32'(inv_hc) + 32'(inv_hi) + 32'(inv_lo) + 32'(to[31:16]) + 32'(to[15:0]);
    acc = (acc & 32'hFFFF) + (acc >> 16);
    acc = (acc & 32'hFFFF) + (acc >> 16);
    return ~acc[15:0];
  endfunction

  function automatic logic [15:0] l4_swap(input logic [7:0] proto, input logic [15:0] hc,
                                          input logic [31:0] from, input logic [31:0] to);
    logic [15:0] r;
    if (proto == PROTO_UDP && hc == 16'h0000) return 16'h0000;
    r = csum_swap(hc, from, to);
    if (proto == PROTO_UDP && r == 16'h0000) r = 16'hFFFF;
    return r;
  endfunction

  function automatic int find_client(input logic [47:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (sess_valid[i] && sess_client[i] == key) return i;
    return -1;
  endfunction

  function void translate_header(input hdr_t h, output rewrite_t r);
    int hit;
    int slot;
    r.verdict = VERDICT_PASS;
    r.src = h.src;
    r.dst = h.dst;
    r.ipc = h.ipc;
    r.l4c = h.l4c;
    r.full = 1'b0;
    if (h.proto == PROTO_TCP || h.proto == PROTO_UDP) begin
      if (h.dport == cur_trigger && h.src != cur_redirect) begin
        if (find_client({h.src, h.sport}) < 0) begin
          if (sess_used < SLOTS) begin
            slot = 0;
            while (sess_valid[slot]) slot++;
            sess_valid[slot] = 1'b1;
            sess_client[slot] = {h.src, h.sport};
            sess_server[slot] = h.dst;
            sess_used++;
            n_recorded++;
          end else begin
            r.full = 1'b1;
            n_refused++;
          end
        end
        r.dst = cur_redirect;
        r.ipc = csum_swap(h.ipc, h.dst, cur_redirect);
        r.l4c = l4_swap(h.proto, h.l4c, h.dst, cur_redirect);
        r.verdict = VERDICT_FWD;
      end else if (h.src == cur_redirect && h.sport == cur_trigger) begin
        hit = find_client({h.dst, h.dport});
        if (hit >= 0) begin
          r.src = sess_server[hit];
          r.ipc = csum_swap(h.ipc, h.src, r.src);
          r.l4c = l4_swap(h.proto, h.l4c, h.src, r.src);
          r.verdict = VERDICT_REPLY;
        end
      end
    end
    case (r.verdict)
      VERDICT_FWD:   n_fwd++;
      VERDICT_REPLY: n_reply++;
      default:       n_pass++;
    endcase
    n_requests++;
  endfunction

  task report(input string what, input logic [31:0] got, input logic [31:0] want);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
  endtask

  // Header source: presents queued requests, translating each one as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        translate_header(hdr_t'(s_tdata), pred_r);
        rewrite_q.push_back(pred_r);
      end
      if (!s_tvalid || s_tready) begin
        if (header_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          s_tvalid <= 1'b1;
          s_tdata <= header_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result sink: random backpressure and field-by-field comparison.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (rewrite_q.size() == 0) begin
        report("unrequested result", m_tdata[31:0], '0);
      end else begin
        want_r = rewrite_q.pop_front();
        if (m_tuser[1:0] != want_r.verdict)
          report("verdict", 32'(m_tuser[1:0]), 32'(want_r.verdict));
        if (m_tuser[2] != want_r.full)
          report("table_full", 32'(m_tuser[2]), 32'(want_r.full));
        if (m_tdata[31:0] != want_r.src) report("out_src_addr", m_tdata[31:0], want_r.src);
        if (m_tdata[63:32] != want_r.dst) report("out_dst_addr", m_tdata[63:32], want_r.dst);
        if (m_tdata[79:64] != want_r.ipc)
          report("out_ip_checksum", 32'(m_tdata[79:64]), 32'(want_r.ipc));
        if (m_tdata[95:80] != want_r.l4c)
          report("out_l4_checksum", 32'(m_tdata[95:80]), 32'(want_r.l4c));
      end
    end
    if (rst) m_tready <= 1'b0;
    else m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_TRIGGER_PORT) cur_trigger = val[15:0];
    else cur_redirect = val;
  endtask

  task set_policy(input logic [15:0] port, input logic [31:0] host);
    write_reg(CFG_TRIGGER_PORT, {16'h0000, port});
    write_reg(CFG_REDIRECT_ADDR, host);
    n_settings++;
  endtask

  task wait_drained();
    while (header_q.size() != 0 || s_tvalid || rewrite_q.size() != 0) @(posedge clk);
  endtask

  function automatic hdr_t mk(input logic [7:0] p, input logic [31:0] s, input logic [31:0] d,
                              input logic [15:0] sp, input logic [15:0] dp,
                              input logic [15:0] ic, input logic [15:0] lc);
    hdr_t h;
    h.proto = p;
    h.src = s;
    h.dst = d;
    h.sport = sp;
    h.dport = dp;
    h.ipc = ic;
    h.l4c = lc;
    return h;
  endfunction

  // Mostly well-formed forward and reply traffic around a bounded client pool, so
  // the table fills up and later requests meet the full case.
  task queue_random_header();
    hdr_t        h;
    int          roll;
    logic [47:0] key;
    h = mk(8'($urandom()), $urandom(), $urandom(), 16'($urandom()), 16'($urandom()),
           16'($urandom()), 16'($urandom()));
    roll = $urandom_range(0, 99);
    if (roll < 85) h.proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
    if (roll < 45) begin
      if (client_pool.size() == 0 ||
          (client_pool.size() < 100 && $urandom_range(0, 99) < 55)) begin
        key = {$urandom(), 16'($urandom())};
        client_pool.push_back(key);
      end else begin
        key = client_pool[$urandom_range(0, client_pool.size() - 1)];
      end
      h.src = key[47:16];
      h.sport = key[15:0];
      h.dport = cur_trigger;
    end else if (roll < 75) begin
      h.src = cur_redirect;
      h.sport = cur_trigger;
      if (client_pool.size() != 0 && $urandom_range(0, 99) < 90) begin
        key = client_pool[$urandom_range(0, client_pool.size() - 1)];
        h.dst = key[47:16];
        h.dport = key[15:0];
      end
    end else if (roll >= 85) begin
      if (h.proto == PROTO_TCP || h.proto == PROTO_UDP) h.proto ^= 8'h80;
      if ($urandom_range(0, 1)) h.dport = cur_trigger;
    end
    case ($urandom_range(0, 9))
      0: h.l4c = 16'h0000;
      1: h.l4c = 16'hFFFF;
      2: h.ipc = 16'hFFFF;
      default: ;
    endcase
    header_q.push_back(h);
  endtask

  initial begin
    logic [31:0] redir;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] c3;
    redir = 32'h0A00_0001;
    c1 = 32'hC0A8_0001;
    c2 = 32'hAC10_2002;
    c3 = 32'h0B00_0002;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_policy(16'd80, redir);
    header_q.push_back(mk(8'd1, c1, 32'h0808_0808, 16'd1234, 16'd80, 16'h1234, 16'h5678));
    header_q.push_back(mk(PROTO_TCP, c1, 32'h0808_0808, 16'd1234, 16'd443, 16'h1111, 16'h2222));
    header_q.push_back(mk(PROTO_TCP, c1, 32'h0808_0808, 16'd1234, 16'd80, 16'hB1C2, 16'h0F0F));
    // Same client again towards another server: the first server is kept.
    header_q.push_back(mk(PROTO_TCP, c1, 32'h0909_0909, 16'd1234, 16'd80, 16'h3C3C, 16'hA5A5));
    header_q.push_back(mk(PROTO_TCP, redir, c1, 16'd80, 16'd1234, 16'h7E01, 16'h0102));
    header_q.push_back(mk(PROTO_UDP, redir, c1, 16'd80, 16'd1235, 16'h7E02, 16'h0304));
    header_q.push_back(mk(PROTO_UDP, c2, 32'h0707_0707, 16'd5000, 16'd80, 16'h4321, 16'h0000));
    // Destination already equals the redirect host, so the UDP sum folds to zero.
    header_q.push_back(mk(PROTO_UDP, c2, redir, 16'd5001, 16'd80, 16'hFFFF, 16'hFFFF));
    header_q.push_back(mk(PROTO_UDP, redir, c2, 16'd80, 16'd5000, 16'h0F00, 16'h0000));
    header_q.push_back(mk(PROTO_TCP, c3, 32'h0102_0304, 16'd80, 16'd80, 16'h5555, 16'hAAAA));
    // From the redirect host on the trigger port to the trigger port: a reply.
    header_q.push_back(mk(PROTO_TCP, redir, c3, 16'd80, 16'd80, 16'h6666, 16'h9999));
    header_q.push_back(mk(PROTO_TCP, redir, c3, 16'd81, 16'd80, 16'h6666, 16'h9999));
    header_q.push_back(mk(PROTO_UDP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd80,
                          16'hFFFF, 16'hFFFF));
    header_q.push_back(mk(PROTO_TCP, 32'h0, 32'h0, 16'h0, 16'd80, 16'h0, 16'h0));
    header_q.push_back(mk(PROTO_TCP, redir, 32'h0, 16'd80, 16'h0, 16'h0, 16'h0));
    header_q.push_back(mk(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF));
    header_q.push_back(mk(8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    wait_drained();

    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: set_policy(16'hFFFF, 32'hFFFF_FFFF);
        2: set_policy(16'h0000, 32'h0000_0000);
        default: set_policy(16'($urandom()), $urandom());
      endcase
      quiet = (ph == 3);
      repeat (RANDOM_PER_PHASE) queue_random_header();
      wait_drained();
      quiet = 1'b0;
    end

    repeat (SLOTS + 16) @(posedge clk);
    $display("%0d requests under %0d policies: %0d forward, %0d reply, %0d unchanged",
             n_requests, n_settings, n_fwd, n_reply, n_pass);
    $display("%0d sessions recorded, %0d refused on a full table", n_recorded, n_refused);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
